[rtl/srf_pkg.sv]
// Shared types and constants for the session replay filter.
// No dependencies; imported by the channel interfaces, session_replay_filter and its testbench.
package srf_pkg;

  localparam int CAPACITY  = 1024;
  localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W    = $clog2(CAPACITY + 1);
  localparam int TUPLE_W   = 384;
  localparam int EXPIRY_W  = 33;
  localparam int NOW_W     = 32;
  localparam int TTL_W     = 16;
  localparam logic [TTL_W-1:0] TTL_RESET = 16'd180;

  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef logic [TUPLE_W-1:0] tuple_t;

  typedef struct packed {
    logic [EXPIRY_W-1:0] expiry;
    tuple_t              tuple;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

endpackage

[rtl/srf_channels.sv]
// Valid/ready channel interfaces for the session replay filter.
// Depends on srf_pkg for field widths.
interface srf_in_if import srf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [63:0]      user_hi;
  logic [63:0]      user_lo;
  logic [63:0]      key_hi;
  logic [63:0]      key_lo;
  logic [63:0]      iv_hi;
  logic [63:0]      iv_lo;
  logic [NOW_W-1:0] now_seconds;

  modport source (output valid, kind, user_hi, user_lo, key_hi, key_lo, iv_hi, iv_lo,
                  now_seconds, input ready);
  modport sink   (input valid, kind, user_hi, user_lo, key_hi, key_lo, iv_hi, iv_lo,
                  now_seconds, output ready);
endinterface

interface srf_out_if;
  logic valid;
  logic ready;
  logic is_new;

  modport source (output valid, is_new, input ready);
  modport sink   (input valid, is_new, output ready);
endinterface

interface srf_cfg_if import srf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TTL_W-1:0] ttl_seconds;

  modport source (output valid, ttl_seconds, input ready);
  modport sink   (input valid, ttl_seconds, output ready);
endinterface

[rtl/srf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module srf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/session_replay_filter.sv]
// Session replay filter: anti-replay cache with time-to-live for session keys.
// Depends on srf_pkg, srf_channels (interfaces) and srf_ram.
//
// Usage:
//   in_ch  carries one item per transfer: kind 0 checks the 384-bit key
//          (user, key, iv) at now_seconds, kind 1 clears every stored key.
//   out_ch returns one is_new bit per item, in order.
//   cfg_ch writes ttl_seconds (reset 180); write it only while idle.
// Timing:
//   A check item reads all CAPACITY slots through the single read port of the
//   slot RAM, one slot a cycle, then completes in ST_FIN; a clear item goes
//   straight from its transfer to ST_FIN without a scan.
//   The block works on one item at a time; in_ch.ready is high when idle.
// Reset:
//   rst_n low empties the ring through the fill count and restores the ttl;
//   no clearing pass is needed, slots beyond the fill count are never used.
// Stall:
//   The result is held in an output register; the next item is accepted and
//   scanned while it waits, and only its own completion waits for out_ch.ready.
module session_replay_filter import srf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  srf_in_if.sink     in_ch,
  srf_out_if.source  out_ch,
  srf_cfg_if.sink    cfg_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPACITY - 1);

  logic [1:0]        state_r, state_nxt;
  logic [FILL_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic              cmp_vld_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  logic              hit_r, hit_nxt;
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [TTL_W-1:0]  ttl_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_is_new_r, out_is_new_nxt;

  logic              kind_r;
  tuple_t            tuple_r;
  logic [NOW_W-1:0]  now_r;

  logic              in_xfer;
  logic              rd_en;
  logic              wr_en;
  logic              fin_go;
  logic              slot_hit;
  slot_t             rd_slot;
  slot_t             wr_slot;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.is_new = out_is_new_r;

  assign rd_en  = (state_r == ST_SCAN) && (rd_cnt_r < FILL_MAX);
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign wr_en  = fin_go && (kind_r == KIND_CHECK) && !hit_r;

  assign wr_slot.expiry = {1'b0, now_r} + {{(EXPIRY_W - TTL_W){1'b0}}, ttl_r};
  assign wr_slot.tuple  = tuple_r;

  assign slot_hit = cmp_vld_r && (FILL_W'(cmp_idx_r) < fill_r) &&
                    (rd_slot.tuple == tuple_r) && (rd_slot.expiry > {1'b0, now_r});

  srf_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (write_slot_r),
    .wdata (wr_slot),
    .re    (rd_en),
    .raddr (rd_cnt_r[SLOT_W-1:0]),
    .rdata (rd_slot)
  );

  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    hit_nxt        = hit_r || slot_hit;
    write_slot_nxt = write_slot_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_is_new_nxt = out_is_new_r;
    if (rd_en) begin
      rd_cnt_nxt = rd_cnt_r + 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          rd_cnt_nxt = '0;
          hit_nxt    = 1'b0;
          state_nxt  = (in_ch.kind == KIND_CLEAR) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((rd_cnt_r == FILL_MAX) && !cmp_vld_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt  = 1'b1;
          out_is_new_nxt = (kind_r == KIND_CHECK) && !hit_r;
          state_nxt      = ST_IDLE;
          if (kind_r == KIND_CLEAR) begin
            write_slot_nxt = '0;
            fill_nxt       = '0;
          end else if (!hit_r) begin
            write_slot_nxt = (write_slot_r == SLOT_LAST) ? '0 : write_slot_r + 1'b1;
            fill_nxt       = (fill_r == FILL_MAX) ? fill_r : fill_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_cnt_r     <= '0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      write_slot_r <= '0;
      fill_r       <= '0;
      ttl_r        <= TTL_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      cmp_vld_r    <= rd_en;
      hit_r        <= hit_nxt;
      write_slot_r <= write_slot_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        ttl_r <= cfg_ch.ttl_seconds;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= rd_cnt_r[SLOT_W-1:0];
    out_is_new_r <= out_is_new_nxt;
    if (in_xfer) begin
      kind_r  <= in_ch.kind;
      tuple_r <= {in_ch.user_hi, in_ch.user_lo, in_ch.key_hi, in_ch.key_lo,
                  in_ch.iv_hi, in_ch.iv_lo};
      now_r   <= in_ch.now_seconds;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill count beyond capacity");

  a_clear_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_ch.kind == KIND_CLEAR) |=> state_r == ST_FIN)
    else $error("clear item did not go straight to completion");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en && !cmp_vld_r)
    else $error("slot write overlaps a scan read");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside completion");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go && (kind_r == KIND_CLEAR) |=> (fill_r == '0) && (write_slot_r == '0))
    else $error("clear left stored slots");

endmodule

[tb/session_replay_filter_tb.sv]
// Testbench for session_replay_filter: a directed table, then random session traffic,
// every is_new transfer checked in order against an in-bench replay cache or a typed value.
// Depends on srf_pkg and the srf_channels interfaces from the RTL.
module session_replay_filter_tb import srf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RESET_CYCLES = 7;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int          HOLD_CYCLES  = 3500;
  localparam int          DRAIN_CYCLES = 1100;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 70;
  localparam int          POOL_MAX     = 48;

  localparam tuple_t KEY_ZERO      = '0;
  localparam tuple_t KEY_ONES      = '1;
  localparam tuple_t KEY_IV_NEAR   = {{(TUPLE_W - 1){1'b1}}, 1'b0};
  localparam tuple_t KEY_USER_NEAR = {1'b0, {(TUPLE_W - 1){1'b1}}};
  localparam tuple_t KEY_ALT_A     = {(TUPLE_W / 8){8'hA5}};
  localparam tuple_t KEY_ALT_B     = {(TUPLE_W / 8){8'h5A}};
  localparam logic [NOW_W-1:0] NOW_MAX = '1;

  typedef struct packed {
    logic             kind;
    tuple_t           key;
    logic [NOW_W-1:0] now;
  } session_item_t;

  typedef enum logic {ROW_ITEM, ROW_TTL} row_op_t;

  typedef struct {
    row_op_t          op;
    session_item_t    item;
    logic [TTL_W-1:0] ttl;
    bit               fixed;
    logic             fixed_new;
  } drill_row_t;

  logic clk;
  logic rst_n;

  srf_in_if  item_if();
  srf_out_if verdict_if();
  srf_cfg_if ttl_if();

  session_replay_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (item_if),
    .out_ch (verdict_if),
    .cfg_ch (ttl_if)
  );

  tuple_t              cache_key    [CAPACITY];
  logic [EXPIRY_W-1:0] cache_expiry [CAPACITY];
  bit                  cache_live   [CAPACITY];
  int unsigned         cache_next = 0;
  logic [TTL_W-1:0]    cache_ttl  = TTL_RESET;

  logic        verdict_q[$];
  drill_row_t  drill[$];
  tuple_t      session_pool[$];
  int          mismatches       = 0;
  int          results_seen     = 0;
  int unsigned cycle_count      = 0;
  bit          gaps_on          = 1'b1;
  bit          stalls_on        = 1'b1;
  bit          hold_off_pending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic admit_session(session_item_t it);
    logic [EXPIRY_W-1:0] stamp;
    stamp = {1'b0, it.now};
    if (it.kind == KIND_CLEAR) begin
      foreach (cache_live[i]) cache_live[i] = 1'b0;
      cache_next = 0;
      return 1'b0;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (cache_live[i] && cache_key[i] == it.key && cache_expiry[i] > stamp) return 1'b0;
    end
    cache_key[cache_next]    = it.key;
    cache_expiry[cache_next] = stamp + EXPIRY_W'(cache_ttl);
    cache_live[cache_next]   = 1'b1;
    cache_next               = (cache_next + 1) % CAPACITY;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic tuple_t random_key();
    tuple_t k;
    for (int w = 0; w < TUPLE_W / 32; w++) k[w*32 +: 32] = $urandom;
    return k;
  endfunction

  function automatic void drill_item(logic kind, tuple_t key, logic [NOW_W-1:0] now,
                                     bit fixed, logic fixed_new);
    drill_row_t row;
    row.op        = ROW_ITEM;
    row.item.kind = kind;
    row.item.key  = key;
    row.item.now  = now;
    row.ttl       = '0;
    row.fixed     = fixed;
    row.fixed_new = fixed_new;
    drill.insert(drill.size(), row);
  endfunction

  function automatic void drill_ttl(logic [TTL_W-1:0] ttl);
    drill_row_t row;
    row.op        = ROW_TTL;
    row.item      = '0;
    row.ttl       = ttl;
    row.fixed     = 1'b0;
    row.fixed_new = 1'b0;
    drill.insert(drill.size(), row);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_session(input session_item_t it, input bit fixed, input logic fixed_new);
    int   gap;
    logic want;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid       <= 1'b1;
    item_if.kind        <= it.kind;
    item_if.user_hi     <= it.key[383:320];
    item_if.user_lo     <= it.key[319:256];
    item_if.key_hi      <= it.key[255:192];
    item_if.key_lo      <= it.key[191:128];
    item_if.iv_hi       <= it.key[127:64];
    item_if.iv_lo       <= it.key[63:0];
    item_if.now_seconds <= it.now;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    want = admit_session(it);
    verdict_q.insert(verdict_q.size(), fixed ? fixed_new : want);
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [TTL_W-1:0] ttl);
    drain();
    ttl_if.valid       <= 1'b1;
    ttl_if.ttl_seconds <= ttl;
    do @(posedge clk); while (ttl_if.ready !== 1'b1);
    ttl_if.valid <= 1'b0;
    cache_ttl = ttl;
  endtask

  task automatic run_phase(input int p);
    logic [TTL_W-1:0] ttl;
    logic [NOW_W:0]   ahead;
    logic [NOW_W-1:0] now;
    session_item_t    it;
    int               roll;
    int               span;
    case (p)
      0: ttl = 16'd1;
      1: ttl = '1;
      2: ttl = '0;
      3: ttl = TTL_RESET;
      default: begin
        if ($urandom_range(1) == 1) ttl = TTL_W'($urandom_range(400, 2));
        else ttl = TTL_W'($urandom_range(65535, 1));
      end
    endcase
    write_ttl(ttl);
    now       = (p % 3 == 1) ? NOW_MAX - NOW_W'($urandom_range(20000)) : NOW_W'($urandom);
    gaps_on   = (p != 5) && (p != 3);
    stalls_on = (p != 5);
    if (p == 3) hold_off_pending = 1'b1;
    span = int'(ttl) + 1;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      roll    = $urandom_range(99);
      it.kind = KIND_CHECK;
      it.key  = random_key();
      if (roll < 4) begin
        it.kind = KIND_CLEAR;
      end else if (roll < 54 && session_pool.size() != 0) begin
        it.key = session_pool[$urandom_range(session_pool.size() - 1)];
      end else if (roll < 64 && session_pool.size() != 0) begin
        it.key = session_pool[$urandom_range(session_pool.size() - 1)];
        it.key[$urandom_range(TUPLE_W - 1)] ^= 1'b1;
      end else begin
        session_pool.insert(session_pool.size(), it.key);
        if (session_pool.size() > POOL_MAX) session_pool.delete(0);
      end
      roll  = $urandom_range(99);
      ahead = {1'b0, now};
      if (roll >= 35 && roll < 80) ahead = ahead + (NOW_W + 1)'($urandom_range(span / 2));
      else if (roll >= 80 && roll < 95) ahead = ahead + (NOW_W + 1)'($urandom_range(2 * span));
      if (roll >= 95) now = now - NOW_W'($urandom_range(span));
      else now = ahead[NOW_W] ? NOW_MAX : ahead[NOW_W-1:0];
      it.now = now;
      send_session(it, 1'b0, 1'b0);
    end
  endtask

  initial begin : receiver
    verdict_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        verdict_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_pending = 1'b0;
      end else if (!stalls_on || $urandom_range(1) == 1) begin
        verdict_if.ready <= 1'b1;
        repeat ($urandom_range(40, 1)) @(posedge clk);
      end else begin
        verdict_if.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : verdict_check
    logic want;
    if (rst_n && verdict_if.valid && verdict_if.ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("is_new %0b transferred with no item pending",
                                verdict_if.is_new));
      end else begin
        want = verdict_q[0];
        verdict_q.delete(0);
        if (verdict_if.is_new !== want)
          flag_mismatch($sformatf("result %0d: is_new %0b, expected %0b",
                                  results_seen, verdict_if.is_new, want));
      end
    end
  end

  initial begin : stimulus
    rst_n               <= 1'b0;
    item_if.valid       <= 1'b0;
    item_if.kind        <= KIND_CHECK;
    item_if.user_hi     <= '0;
    item_if.user_lo     <= '0;
    item_if.key_hi      <= '0;
    item_if.key_lo      <= '0;
    item_if.iv_hi       <= '0;
    item_if.iv_lo       <= '0;
    item_if.now_seconds <= '0;
    ttl_if.valid        <= 1'b0;
    ttl_if.ttl_seconds  <= TTL_RESET;
    foreach (cache_live[i]) cache_live[i] = 1'b0;

    // kind, key, now, typed?, typed is_new
    drill_item(KIND_CHECK, KEY_ZERO,      32'd0,           1'b1, 1'b1);
    drill_item(KIND_CHECK, KEY_ZERO,      32'd0,           1'b1, 1'b0);
    drill_item(KIND_CHECK, KEY_ONES,      32'd0,           1'b1, 1'b1);
    drill_item(KIND_CHECK, KEY_ONES,      32'd179,         1'b1, 1'b0);
    drill_item(KIND_CHECK, KEY_ONES,      32'd180,         1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_ONES,      32'd181,         1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_IV_NEAR,   32'd181,         1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_USER_NEAR, 32'd181,         1'b0, 1'b0);
    drill_item(KIND_CLEAR, KEY_ONES,      32'd200,         1'b1, 1'b0);
    drill_item(KIND_CHECK, KEY_ONES,      32'd200,         1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_ZERO,      32'd100,         1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_ZERO,      32'd50,          1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_ALT_A,     NOW_MAX,         1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_ALT_A,     NOW_MAX,         1'b0, 1'b0);
    drill_item(KIND_CLEAR, KEY_ALT_B,     NOW_MAX,         1'b1, 1'b0);
    drill_ttl(16'd0);
    drill_item(KIND_CHECK, KEY_ALT_B,     32'd5,           1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_ALT_B,     32'd5,           1'b0, 1'b0);
    drill_ttl(16'hFFFF);
    drill_item(KIND_CHECK, KEY_ALT_A,     32'hFFFF_0000,   1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_ALT_A,     NOW_MAX,         1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_ALT_B,     NOW_MAX,         1'b0, 1'b0);
    drill_ttl(16'd1);
    drill_item(KIND_CHECK, KEY_ZERO,      32'd10,          1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_ZERO,      32'd10,          1'b0, 1'b0);
    drill_item(KIND_CHECK, KEY_ZERO,      32'd11,          1'b0, 1'b0);
    drill_item(KIND_CLEAR, KEY_ZERO,      32'd11,          1'b1, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (drill[r]) begin
      if (drill[r].op == ROW_TTL) write_ttl(drill[r].ttl);
      else send_session(drill[r].item, drill[r].fixed, drill[r].fixed_new);
    end
    for (int p = 0; p < PHASES; p++) run_phase(p);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[session_replay_filter.f]
rtl/srf_pkg.sv
rtl/srf_channels.sv
rtl/srf_ram.sv
rtl/session_replay_filter.sv
tb/session_replay_filter_tb.sv
